// File: hdl/pdi_pkg.sv
// Package for the disk interface register block: access types, register
// codes, address windows and bit positions. No dependencies.
package pdi_pkg;

    localparam logic [15:0] PIA_END      = 16'h3800;
    localparam logic [15:0] PIA_BASE     = 16'h3000;
    localparam logic [15:0] FDC_BASE     = 16'h2800;
    localparam logic [7:0]  BYTE_ALL     = 8'hFF;
    localparam int          CTRL_DATASEL = 2;   // control bit: data (1) / direction (0)
    localparam int          BUSY_BIT     = 6;
    localparam int          DRIVE_BIT    = 1;
    localparam int          SIDE_BIT     = 4;

    typedef enum logic [1:0] {
        REG_PORT_A = 2'd0,
        REG_CTRL_A = 2'd1,
        REG_PORT_B = 2'd2,
        REG_CTRL_B = 2'd3
    } t_pia_reg;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef struct packed {
        logic        op;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        motor_on;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       fdc_access;
        logic [1:0] fdc_register;
        logic       drive_select;
        logic       head_side;
        logic       motor_swap;
        logic       printer_valid;
        logic [7:0] printer_byte;
    } t_result;

    typedef struct packed {
        logic [7:0] port_a_data;
        logic [7:0] port_a_direction;
        logic [7:0] port_a_control;
        logic [7:0] port_b_data;
        logic [7:0] port_b_direction;
        logic [7:0] port_b_control;
        logic       active_drive;
    } t_state;

endpackage

// File: hdl/pdi_access_unit.sv
// Decode of one bus access against the current register state: next state
// and result item. Combinational. Depends on pdi_pkg.
module pdi_access_unit (
    input  pdi_pkg::t_item   i_item,
    input  pdi_pkg::t_state  i_state,
    output pdi_pkg::t_state  o_state,
    output pdi_pkg::t_result o_result
);
    import pdi_pkg::*;

    logic     wr;
    logic     in_pia;
    logic     in_fdc;
    logic     new_drive;
    t_pia_reg sel;
    t_state   nxt;
    t_result  res;

    always_comb begin
        wr        = (i_item.op == OP_WRITE);
        in_pia    = (i_item.address >= PIA_BASE) && (i_item.address < PIA_END);
        in_fdc    = (i_item.address >= FDC_BASE) && (i_item.address < PIA_BASE);
        sel       = t_pia_reg'(i_item.address[1:0]);
        new_drive = i_item.write_data[DRIVE_BIT];
        nxt       = i_state;

        res               = '0;
        res.read_data     = wr ? 8'h00 : BYTE_ALL;
        res.fdc_access    = in_fdc;
        res.fdc_register  = in_fdc ? i_item.address[1:0] : 2'd0;

        if (in_pia) begin
            case (sel)
                REG_PORT_A: begin
                    if (wr) begin
                        if (i_state.port_a_control[CTRL_DATASEL]) begin
                            nxt.port_a_data  = i_item.write_data;
                            nxt.active_drive = new_drive;
                            res.motor_swap   = (new_drive != i_state.active_drive)
                                               && i_item.motor_on;
                        end else begin
                            nxt.port_a_direction = i_item.write_data;
                        end
                    end else begin
                        if (i_state.port_a_control[CTRL_DATASEL]) begin
                            // printer never busy: drop the busy bit on read
                            nxt.port_a_data[BUSY_BIT] = 1'b0;
                            res.read_data             = nxt.port_a_data;
                        end else begin
                            res.read_data = i_state.port_a_direction;
                        end
                    end
                end
                REG_CTRL_A: begin
                    if (wr) begin
                        nxt.port_a_control = i_item.write_data;
                    end else begin
                        res.read_data           = i_state.port_a_control;
                        res.read_data[BUSY_BIT] = 1'b1;
                    end
                end
                REG_PORT_B: begin
                    if (wr) begin
                        if (i_state.port_b_control[CTRL_DATASEL]) begin
                            nxt.port_b_data   = i_item.write_data;
                            res.printer_valid = 1'b1;
                            res.printer_byte  = i_item.write_data;
                        end else begin
                            nxt.port_b_direction = i_item.write_data;
                        end
                    end else begin
                        res.read_data = i_state.port_b_control[CTRL_DATASEL]
                                        ? i_state.port_b_data : i_state.port_b_direction;
                    end
                end
                REG_CTRL_B: begin
                    if (wr) begin
                        nxt.port_b_control = i_item.write_data;
                    end else begin
                        res.read_data = i_state.port_b_control;
                    end
                end
                default: begin
                    nxt = i_state;
                end
            endcase
        end

        res.drive_select = nxt.active_drive;
        res.head_side    = nxt.port_a_data[SIDE_BIT];
    end

    assign o_state  = nxt;
    assign o_result = res;

endmodule

// File: hdl/pdi_reg_file.sv
// PIA register state and selected drive, updated once per processed item.
// Depends on pdi_pkg.
module pdi_reg_file (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_update,
    input  pdi_pkg::t_state i_next,
    output pdi_pkg::t_state o_state
);
    import pdi_pkg::*;

    t_state r_state;
    t_state n_state;

    assign n_state = i_update ? i_next : r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

// File: hdl/pia_disk_interface_regs.sv
// Top level of the disk interface register block: input register, access
// decode, register state and result register. Depends on pdi_pkg,
// pdi_access_unit and pdi_reg_file.
//
//   channel  | handshake         | payload
//   ---------+-------------------+------------------------------------------
//   access   | i_valid / o_ready | i_op, i_address, i_write_data, i_motor_on
//   result   | o_valid / i_ready | o_read_data, o_fdc_access, o_fdc_register,
//            |                   | o_drive_select, o_head_side, o_motor_swap,
//            |                   | o_printer_valid, o_printer_byte
//
// One item per cycle while the result is drained; results are registered.
// The item is decoded and the registers updated as it moves from the input
// register to the result register, so each item sees the previous one's state.
// Synchronous active-low reset clears the PIA registers, drive zero, and both
// valid flags. A stalled result holds the result register; the input register
// still takes one item while the result waits.
module pia_disk_interface_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic        i_motor_on,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_data,
    output logic        o_fdc_access,
    output logic [1:0]  o_fdc_register,
    output logic        o_drive_select,
    output logic        o_head_side,
    output logic        o_motor_swap,
    output logic        o_printer_valid,
    output logic [7:0]  o_printer_byte
);
    import pdi_pkg::*;

    logic    r_in_valid;
    logic    n_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_result;
    logic    advance;
    logic    take_in;
    t_state  state;
    t_state  state_next;
    t_result result;

    // advance the held item when the result register is free or being drained
    assign advance     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || advance;
    assign take_in     = i_valid && o_ready;
    assign n_in_valid  = take_in || (r_in_valid && !advance);
    assign n_out_valid = advance || (r_out_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_item.op         <= i_op;
            r_item.address    <= i_address;
            r_item.write_data <= i_write_data;
            r_item.motor_on   <= i_motor_on;
        end
        if (advance) begin
            r_result <= result;
        end
    end

    pdi_access_unit u_access (
        .i_item   (r_item),
        .i_state  (state),
        .o_state  (state_next),
        .o_result (result)
    );

    pdi_reg_file u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (advance),
        .i_next   (state_next),
        .o_state  (state)
    );

    assign o_valid         = r_out_valid;
    assign o_read_data     = r_result.read_data;
    assign o_fdc_access    = r_result.fdc_access;
    assign o_fdc_register  = r_result.fdc_register;
    assign o_drive_select  = r_result.drive_select;
    assign o_head_side     = r_result.head_side;
    assign o_motor_swap    = r_result.motor_swap;
    assign o_printer_valid = r_result.printer_valid;
    assign o_printer_byte  = r_result.printer_byte;

endmodule
